// ===== hw/rtl/lac_pkg.sv =====
// Shared widths, latencies and constants of the look-at view matrix core.
`default_nettype none

package lac_pkg;

    parameter int FIX_W      = 32;
    parameter int CR_W       = 2 * FIX_W + 1;
    parameter int UNIT_W     = 18;
    parameter int V_W        = 20;
    parameter int SM_W       = 31;
    parameter int SQRT_STEPS = 32;
    parameter int DIV_STEPS  = 17;
    parameter int NORM_LAT   = 6 + SQRT_STEPS + DIV_STEPS + 1;

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic signed [V_W-1:0]    vcomp_t;

    parameter fix_t FIX_ONE = 32'sd65536;

endpackage

`default_nettype wire

// ===== hw/rtl/look_at_view_matrix_core.sv =====
// Look-at view matrix core: Q16.16 camera basis, view matrix and its inverse.
//
// Input channel (s_*): one word carries the reference point, the view plane
// normal and the up vector, all Q16.16. Output channel (m_*): each input
// word yields eight row words, the forward matrix rows 0..3 then the inverse
// rows 0..3; m_last marks the eighth. A zero normal or an up vector parallel
// to the normal sets m_degenerate on all eight rows and zeroes their columns.
// The datapath is a 65-stage pipeline that takes one word per cycle while
// it is not frozen; its depth is set by the bit-per-stage square root (32)
// and divider (17). The output register holds one item and sends one row
// per cycle while m_ready is high, so the single output port, with its
// eight rows per item, sets how fast the block can take new input words.
// While the output register is busy the pipeline keeps taking words until
// its last stage holds a finished item; the whole pipeline then freezes
// until the eighth row is taken, losing and repeating nothing.
// aresetn is synchronous, active low, and clears all valid flags.
`default_nettype none

module look_at_view_matrix_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire signed [31:0]   s_ref_x,
    input  wire signed [31:0]   s_ref_y,
    input  wire signed [31:0]   s_ref_z,
    input  wire signed [31:0]   s_normal_x,
    input  wire signed [31:0]   s_normal_y,
    input  wire signed [31:0]   s_normal_z,
    input  wire signed [31:0]   s_up_x,
    input  wire signed [31:0]   s_up_y,
    input  wire signed [31:0]   s_up_z,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic                m_which_matrix,
    output logic [1:0]          m_row_index,
    output logic signed [31:0]  m_col0,
    output logic signed [31:0]  m_col1,
    output logic signed [31:0]  m_col2,
    output logic signed [31:0]  m_col3,
    output logic                m_degenerate,
    output logic                m_last
);

    localparam int FW    = lac_pkg::FIX_W;
    localparam int CW    = lac_pkg::CR_W;
    localparam int PRD_W = 2 * FW;
    localparam int VP_W  = 2 * lac_pkg::UNIT_W;
    localparam int VD_W  = VP_W + 1;
    localparam int UP_W  = lac_pkg::UNIT_W + FW;
    localparam int WP_W  = lac_pkg::V_W + FW;
    localparam int DOT_W = WP_W + 2;
    localparam int QW    = DOT_W - 15;
    localparam int S_N   = 3 + lac_pkg::NORM_LAT;
    localparam int LAT   = S_N + 6;

    typedef lac_pkg::fix_t   fix_t;
    typedef lac_pkg::unit_t  unit_t;
    typedef lac_pkg::vcomp_t vcomp_t;

    function automatic fix_t neg_rnd_sat(input logic signed [DOT_W-1:0] x);
        logic [DOT_W-1:0]      mg;
        logic [DOT_W:0]        t;
        logic [QW-1:0]         q;
        logic signed [QW:0]    r;
        mg = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
        t  = {1'b0, mg} + (DOT_W+1)'(32768);
        q  = t[DOT_W:16];
        r  = x[DOT_W-1] ? $signed({1'b0, q}) : -$signed({1'b0, q});
        if (!r[QW] && (|r[QW-1:FW-1])) begin
            return {1'b0, {(FW-1){1'b1}}};
        end else if (r[QW] && !(&r[QW-1:FW-1])) begin
            return {1'b1, {(FW-1){1'b0}}};
        end
        return r[FW-1:0];
    endfunction

    function automatic vcomp_t rnd_v(input logic signed [VD_W-1:0] x);
        logic [VD_W-1:0]            mg;
        logic [VD_W:0]              t;
        logic [VD_W-16:0]           q;
        logic signed [VD_W-15:0]    r;
        mg = x[VD_W-1] ? VD_W'(-x) : VD_W'(x);
        t  = {1'b0, mg} + (VD_W+1)'(32768);
        q  = t[VD_W:16];
        r  = x[VD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return r[lac_pkg::V_W-1:0];
    endfunction

    logic                   adv;
    logic                   fin_v;
    logic                   take;
    logic                   done;
    logic                   load;

    logic [LAT:1]           vld_reg;
    fix_t                   p_line_reg [1:LAT][3];
    logic                   dg_line_reg [4:LAT];

    fix_t                   nr1_reg [3];
    fix_t                   up1_reg [3];
    logic signed [PRD_W-1:0] pr2_reg [6];
    fix_t                   nr2_reg [3];
    logic signed [CW-1:0]   cr3_reg [3];
    fix_t                   nr3_reg [3];

    unit_t                  nn [3];
    unit_t                  uu [3];

    logic signed [VP_W-1:0] vp60_reg [6];
    logic signed [UP_W-1:0] up60_reg [3];
    logic signed [UP_W-1:0] np60_reg [3];
    unit_t                  n60_reg [3];
    unit_t                  u60_reg [3];

    logic signed [VD_W-1:0]  vd61_reg [3];
    logic signed [DOT_W-1:0] ud61_reg;
    logic signed [DOT_W-1:0] nd61_reg;
    unit_t                   n61_reg [3];
    unit_t                   u61_reg [3];

    vcomp_t                 v62_reg [3];
    fix_t                   tu62_reg;
    fix_t                   tn62_reg;
    unit_t                  n62_reg [3];
    unit_t                  u62_reg [3];

    logic signed [WP_W-1:0] vp63_reg [3];
    vcomp_t                 v63_reg [3];
    fix_t                   tu63_reg;
    fix_t                   tn63_reg;
    unit_t                  n63_reg [3];
    unit_t                  u63_reg [3];

    logic signed [DOT_W-1:0] vd64_reg;
    vcomp_t                 v64_reg [3];
    fix_t                   tu64_reg;
    fix_t                   tn64_reg;
    unit_t                  n64_reg [3];
    unit_t                  u64_reg [3];

    fix_t                   tv65_reg;
    vcomp_t                 v65_reg [3];
    fix_t                   tu65_reg;
    fix_t                   tn65_reg;
    unit_t                  n65_reg [3];
    unit_t                  u65_reg [3];

    logic                   ob_busy_reg;
    logic                   ob_busy_next;
    logic [2:0]             ob_row_reg;
    logic [2:0]             ob_row_next;
    unit_t                  ob_u_reg [3];
    vcomp_t                 ob_v_reg [3];
    unit_t                  ob_n_reg [3];
    fix_t                   ob_tu_reg;
    fix_t                   ob_tv_reg;
    fix_t                   ob_tn_reg;
    fix_t                   ob_p_reg [3];
    logic                   ob_dg_reg;

    fix_t                   col [4];

    assign fin_v   = vld_reg[LAT];
    assign take    = ob_busy_reg && m_ready;
    assign done    = take && (ob_row_reg == 3'd7);
    assign load    = fin_v && (!ob_busy_reg || done);
    assign adv     = !fin_v || load;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-1:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_line_reg[1] <= '{s_ref_x, s_ref_y, s_ref_z};
            for (int k = 2; k <= LAT; k++) begin
                p_line_reg[k] <= p_line_reg[k-1];
            end
            dg_line_reg[4] <= (cr3_reg[0] == '0) && (cr3_reg[1] == '0)
                              && (cr3_reg[2] == '0);
            for (int k = 5; k <= LAT; k++) begin
                dg_line_reg[k] <= dg_line_reg[k-1];
            end

            nr1_reg <= '{s_normal_x, s_normal_y, s_normal_z};
            up1_reg <= '{s_up_x, s_up_y, s_up_z};

            pr2_reg[0] <= up1_reg[1] * nr1_reg[2];
            pr2_reg[1] <= up1_reg[2] * nr1_reg[1];
            pr2_reg[2] <= up1_reg[2] * nr1_reg[0];
            pr2_reg[3] <= up1_reg[0] * nr1_reg[2];
            pr2_reg[4] <= up1_reg[0] * nr1_reg[1];
            pr2_reg[5] <= up1_reg[1] * nr1_reg[0];
            nr2_reg    <= nr1_reg;

            for (int i = 0; i < 3; i++) begin
                cr3_reg[i] <= CW'(pr2_reg[2*i]) - CW'(pr2_reg[2*i+1]);
            end
            nr3_reg <= nr2_reg;

            vp60_reg[0] <= nn[1] * uu[2];
            vp60_reg[1] <= nn[2] * uu[1];
            vp60_reg[2] <= nn[2] * uu[0];
            vp60_reg[3] <= nn[0] * uu[2];
            vp60_reg[4] <= nn[0] * uu[1];
            vp60_reg[5] <= nn[1] * uu[0];
            for (int i = 0; i < 3; i++) begin
                up60_reg[i] <= uu[i] * p_line_reg[S_N][i];
                np60_reg[i] <= nn[i] * p_line_reg[S_N][i];
            end
            n60_reg <= nn;
            u60_reg <= uu;

            for (int i = 0; i < 3; i++) begin
                vd61_reg[i] <= VD_W'(vp60_reg[2*i]) - VD_W'(vp60_reg[2*i+1]);
            end
            ud61_reg <= DOT_W'(up60_reg[0]) + DOT_W'(up60_reg[1]) + DOT_W'(up60_reg[2]);
            nd61_reg <= DOT_W'(np60_reg[0]) + DOT_W'(np60_reg[1]) + DOT_W'(np60_reg[2]);
            n61_reg  <= n60_reg;
            u61_reg  <= u60_reg;

            for (int i = 0; i < 3; i++) begin
                v62_reg[i] <= rnd_v(vd61_reg[i]);
            end
            tu62_reg <= neg_rnd_sat(ud61_reg);
            tn62_reg <= neg_rnd_sat(nd61_reg);
            n62_reg  <= n61_reg;
            u62_reg  <= u61_reg;

            for (int i = 0; i < 3; i++) begin
                vp63_reg[i] <= v62_reg[i] * p_line_reg[S_N+3][i];
            end
            v63_reg  <= v62_reg;
            tu63_reg <= tu62_reg;
            tn63_reg <= tn62_reg;
            n63_reg  <= n62_reg;
            u63_reg  <= u62_reg;

            vd64_reg <= DOT_W'(vp63_reg[0]) + DOT_W'(vp63_reg[1]) + DOT_W'(vp63_reg[2]);
            v64_reg  <= v63_reg;
            tu64_reg <= tu63_reg;
            tn64_reg <= tn63_reg;
            n64_reg  <= n63_reg;
            u64_reg  <= u63_reg;

            tv65_reg <= neg_rnd_sat(vd64_reg);
            v65_reg  <= v64_reg;
            tu65_reg <= tu64_reg;
            tn65_reg <= tn64_reg;
            n65_reg  <= n64_reg;
            u65_reg  <= u64_reg;
        end
    end

    lac_norm #(
        .W  (FW)
    ) u_norm_n (
        .aclk (aclk),
        .en   (adv),
        .c0   (nr3_reg[0]),
        .c1   (nr3_reg[1]),
        .c2   (nr3_reg[2]),
        .q0   (nn[0]),
        .q1   (nn[1]),
        .q2   (nn[2])
    );

    lac_norm #(
        .W  (CW)
    ) u_norm_u (
        .aclk (aclk),
        .en   (adv),
        .c0   (cr3_reg[0]),
        .c1   (cr3_reg[1]),
        .c2   (cr3_reg[2]),
        .q0   (uu[0]),
        .q1   (uu[1]),
        .q2   (uu[2])
    );

    always_comb begin
        ob_busy_next = ob_busy_reg;
        ob_row_next  = ob_row_reg;
        if (load) begin
            ob_busy_next = 1'b1;
            ob_row_next  = '0;
        end else if (done) begin
            ob_busy_next = 1'b0;
        end else if (take) begin
            ob_row_next = ob_row_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_busy_reg <= 1'b0;
            ob_row_reg  <= '0;
        end else begin
            ob_busy_reg <= ob_busy_next;
            ob_row_reg  <= ob_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ob_u_reg  <= u65_reg;
            ob_v_reg  <= v65_reg;
            ob_n_reg  <= n65_reg;
            ob_tu_reg <= tu65_reg;
            ob_tv_reg <= tv65_reg;
            ob_tn_reg <= tn65_reg;
            ob_p_reg  <= p_line_reg[LAT];
            ob_dg_reg <= dg_line_reg[LAT];
        end
    end

    always_comb begin
        col = '{'0, '0, '0, lac_pkg::FIX_ONE};
        unique case (ob_row_reg)
            3'd0: col = '{FW'(ob_u_reg[0]), FW'(ob_u_reg[1]), FW'(ob_u_reg[2]), ob_tu_reg};
            3'd1: col = '{FW'(ob_v_reg[0]), FW'(ob_v_reg[1]), FW'(ob_v_reg[2]), ob_tv_reg};
            3'd2: col = '{FW'(ob_n_reg[0]), FW'(ob_n_reg[1]), FW'(ob_n_reg[2]), ob_tn_reg};
            3'd4: col = '{FW'(ob_u_reg[0]), FW'(ob_v_reg[0]), FW'(ob_n_reg[0]), ob_p_reg[0]};
            3'd5: col = '{FW'(ob_u_reg[1]), FW'(ob_v_reg[1]), FW'(ob_n_reg[1]), ob_p_reg[1]};
            3'd6: col = '{FW'(ob_u_reg[2]), FW'(ob_v_reg[2]), FW'(ob_n_reg[2]), ob_p_reg[2]};
            default: col = '{'0, '0, '0, lac_pkg::FIX_ONE};
        endcase
        if (ob_dg_reg) begin
            col = '{'0, '0, '0, '0};
        end
    end

    assign m_valid        = ob_busy_reg;
    assign m_which_matrix = ob_row_reg[2];
    assign m_row_index    = ob_row_reg[1:0];
    assign m_col0         = col[0];
    assign m_col1         = col[1];
    assign m_col2         = col[2];
    assign m_col3         = col[3];
    assign m_degenerate   = ob_dg_reg;
    assign m_last         = (ob_row_reg == 3'd7);

endmodule

`default_nettype wire

// ===== hw/rtl/lac_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
`default_nettype none

module lac_norm #(
    parameter int W = lac_pkg::FIX_W
) (
    input  wire                  aclk,
    input  wire                  en,
    input  wire signed [W-1:0]   c0,
    input  wire signed [W-1:0]   c1,
    input  wire signed [W-1:0]   c2,
    output lac_pkg::unit_t       q0,
    output lac_pkg::unit_t       q1,
    output lac_pkg::unit_t       q2
);

    localparam int PW = $clog2(W);
    localparam int MW = lac_pkg::SM_W;
    localparam int SQ = lac_pkg::SQRT_STEPS;
    localparam int DV = lac_pkg::DIV_STEPS;
    localparam int SW = 2 * SQ;

    logic signed [W-1:0] cin [3];

    logic [W-1:0]      mag1_reg [3];
    logic [W-1:0]      mag1_next [3];
    logic [2:0]        sg1_reg;

    logic [W-1:0]      mag2_reg [3];
    logic [W-1:0]      mx2_reg;
    logic [W-1:0]      mx2_next;
    logic [2:0]        sg2_reg;

    logic [W-1:0]      mag3_reg [3];
    logic [PW-1:0]     pos3_reg;
    logic [PW-1:0]     pos3_next;
    logic [2:0]        sg3_reg;

    logic [MW-1:0]     sm4_reg [3];
    logic [MW-1:0]     sm4_next [3];
    logic [2:0]        sg4_reg;

    logic [2*MW-1:0]   sq5_reg [3];
    logic [MW-1:0]     sm5_reg [3];
    logic [2:0]        sg5_reg;

    logic [SW-1:0]     rs_reg [SQ+1];
    logic [SW-1:0]     rt_reg [SQ+1];
    logic [MW-1:0]     rm_reg [SQ+1][3];
    logic [2:0]        rsg_reg [SQ+1];

    logic [SQ:0]       dr_reg [1:DV][3];
    logic [DV-1:0]     dq_reg [1:DV][3];
    logic [SQ-1:0]     dl_reg [1:DV];
    logic [2:0]        dsg_reg [1:DV];

    lac_pkg::unit_t    q_reg [3];

    assign cin[0] = c0;
    assign cin[1] = c1;
    assign cin[2] = c2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag1_next[i] = cin[i][W-1] ? (~cin[i] + W'(1)) : cin[i];
        end
    end

    always_comb begin
        mx2_next = mag1_reg[0];
        if (mag1_reg[1] > mx2_next) begin
            mx2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx2_next) begin
            mx2_next = mag1_reg[2];
        end
    end

    always_comb begin
        pos3_next = '0;
        for (int b = 0; b < W; b++) begin
            if (mx2_reg[b]) begin
                pos3_next = PW'(b);
            end
        end
    end

    always_comb begin
        logic [W+MW-1:0] wide;
        logic [W+MW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            wide = {{MW{1'b0}}, mag3_reg[i]};
            if (pos3_reg > PW'(MW - 1)) begin
                sh = wide >> (pos3_reg - PW'(MW - 1));
            end else begin
                sh = wide << (PW'(MW - 1) - pos3_reg);
            end
            sm4_next[i] = sh[MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg   <= mag1_next;
            sg1_reg    <= {cin[2][W-1], cin[1][W-1], cin[0][W-1]};
            mag2_reg   <= mag1_reg;
            mx2_reg    <= mx2_next;
            sg2_reg    <= sg1_reg;
            mag3_reg   <= mag2_reg;
            pos3_reg   <= pos3_next;
            sg3_reg    <= sg2_reg;
            sm4_reg    <= sm4_next;
            sg4_reg    <= sg3_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= sm4_reg[i] * sm4_reg[i];
            end
            sm5_reg    <= sm4_reg;
            sg5_reg    <= sg4_reg;
            rs_reg[0]  <= SW'(sq5_reg[0]) + SW'(sq5_reg[1]) + SW'(sq5_reg[2]);
            rt_reg[0]  <= '0;
            rm_reg[0]  <= sm5_reg;
            rsg_reg[0] <= sg5_reg;
        end
    end

    for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ - j));
        logic [SW-1:0] trial;
        logic [SW-1:0] rs_next;
        logic [SW-1:0] rt_next;

        always_comb begin
            trial = rt_reg[j-1] + BIT;
            if (rs_reg[j-1] >= trial) begin
                rs_next = rs_reg[j-1] - trial;
                rt_next = (rt_reg[j-1] >> 1) + BIT;
            end else begin
                rs_next = rs_reg[j-1];
                rt_next = rt_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rs_reg[j]  <= rs_next;
                rt_reg[j]  <= rt_next;
                rm_reg[j]  <= rm_reg[j-1];
                rsg_reg[j] <= rsg_reg[j-1];
            end
        end
    end

    for (genvar j = 1; j <= DV; j++) begin : g_div
        logic [SQ:0]   rin [3];
        logic [DV-1:0] qin [3];
        logic [SQ-1:0] lin;
        logic [2:0]    sin;
        logic [SQ:0]   dr_next [3];
        logic [DV-1:0] dq_next [3];
        logic          ge;

        if (j == 1) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rin[i] = (SQ+1)'(rm_reg[SQ][i]);
                    qin[i] = '0;
                end
                lin = rt_reg[SQ][SQ-1:0];
                sin = rsg_reg[SQ];
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rin[i] = {dr_reg[j-1][i][SQ-1:0], 1'b0};
                    qin[i] = dq_reg[j-1][i];
                end
                lin = dl_reg[j-1];
                sin = dsg_reg[j-1];
            end
        end

        always_comb begin
            ge = 1'b0;
            for (int i = 0; i < 3; i++) begin
                ge = rin[i] >= {1'b0, lin};
                dr_next[i] = ge ? (rin[i] - {1'b0, lin}) : rin[i];
                dq_next[i] = {qin[i][DV-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dr_reg[j]  <= dr_next;
                dq_reg[j]  <= dq_next;
                dl_reg[j]  <= lin;
                dsg_reg[j] <= sin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                q_reg[i] <= dsg_reg[DV][i] ? -$signed({1'b0, dq_reg[DV][i]})
                                           :  $signed({1'b0, dq_reg[DV][i]});
            end
        end
    end

    assign q0 = q_reg[0];
    assign q1 = q_reg[1];
    assign q2 = q_reg[2];

endmodule

`default_nettype wire

// ===== verif/look_at_checker.sv =====
// Row predictor and scoreboard for the look-at view matrix core.
`timescale 1ns / 100ps

module look_at_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    input  wire        s_ready,
    input  wire [31:0] s_ref_x,
    input  wire [31:0] s_ref_y,
    input  wire [31:0] s_ref_z,
    input  wire [31:0] s_normal_x,
    input  wire [31:0] s_normal_y,
    input  wire [31:0] s_normal_z,
    input  wire [31:0] s_up_x,
    input  wire [31:0] s_up_y,
    input  wire [31:0] s_up_z,
    input  wire        m_valid,
    input  wire        m_ready,
    input  wire        m_which_matrix,
    input  wire [1:0]  m_row_index,
    input  wire [31:0] m_col0,
    input  wire [31:0] m_col1,
    input  wire [31:0] m_col2,
    input  wire [31:0] m_col3,
    input  wire        m_degenerate,
    input  wire        m_last,
    output int         mismatches,
    output int         rows_pending,
    output int         rows_seen,
    output int         degen_items
);

    typedef struct {
        bit         which;
        bit [1:0]   row;
        bit [31:0]  cols[4];
        bit         degen;
        bit         last;
    } matrix_row_t;

    matrix_row_t rows_due[$];

    assign rows_pending = rows_due.size();

    function automatic longint unsigned abs64(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input longint c[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx, len, q;
        for (int i = 0; i < 3; i++) m[i] = abs64(c[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        for (int i = 0; i < 3; i++) o[i] = 0;
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << 16) / len;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic longint round_q16(longint x);
        longint q;
        q = longint'((abs64(x) + 64'h8000) >> 16);
        return x < 0 ? -q : q;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint neg_proj(longint a[3], longint p[3]);
        return clamp32(-round_q16(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]));
    endfunction

    function automatic void push_row(int k, bit which, bit [1:0] r,
                                     longint c0, longint c1, longint c2, longint c3,
                                     bit degen);
        matrix_row_t e;
        e.which = which;
        e.row = r;
        e.cols[0] = degen ? 32'd0 : c0[31:0];
        e.cols[1] = degen ? 32'd0 : c1[31:0];
        e.cols[2] = degen ? 32'd0 : c2[31:0];
        e.cols[3] = degen ? 32'd0 : c3[31:0];
        e.degen = degen;
        e.last = (k == 7);
        rows_due.push_back(e);
    endfunction

    function automatic void predict_matrices(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                                             bit [31:0] nx, bit [31:0] ny, bit [31:0] nz,
                                             bit [31:0] ux, bit [31:0] uy, bit [31:0] uz);
        longint p[3], nr[3], up[3], cr[3], n[3], u[3], v[3];
        longint one;
        bit ok;
        one = longint'(lac_pkg::FIX_ONE);
        p[0] = longint'(signed'(px)); p[1] = longint'(signed'(py)); p[2] = longint'(signed'(pz));
        nr[0] = longint'(signed'(nx)); nr[1] = longint'(signed'(ny)); nr[2] = longint'(signed'(nz));
        up[0] = longint'(signed'(ux)); up[1] = longint'(signed'(uy)); up[2] = longint'(signed'(uz));
        cr[0] = up[1] * nr[2] - up[2] * nr[1];
        cr[1] = up[2] * nr[0] - up[0] * nr[2];
        cr[2] = up[0] * nr[1] - up[1] * nr[0];
        ok = unit_vec(nr, n);
        if (ok) ok = unit_vec(cr, u);
        if (!ok) begin
            for (int i = 0; i < 3; i++) begin
                n[i] = 0;
                u[i] = 0;
            end
            degen_items++;
        end
        v[0] = round_q16(n[1] * u[2] - n[2] * u[1]);
        v[1] = round_q16(n[2] * u[0] - n[0] * u[2]);
        v[2] = round_q16(n[0] * u[1] - n[1] * u[0]);
        push_row(0, 0, 2'd0, u[0], u[1], u[2], neg_proj(u, p), !ok);
        push_row(1, 0, 2'd1, v[0], v[1], v[2], neg_proj(v, p), !ok);
        push_row(2, 0, 2'd2, n[0], n[1], n[2], neg_proj(n, p), !ok);
        push_row(3, 0, 2'd3, 0, 0, 0, one, !ok);
        for (int r = 0; r < 3; r++)
            push_row(4 + r, 1, 2'(r), u[r], v[r], n[r], p[r], !ok);
        push_row(7, 1, 2'd3, 0, 0, 0, one, !ok);
    endfunction

    initial begin
        mismatches = 0;
        rows_seen = 0;
        degen_items = 0;
    end

    always @(posedge aclk) begin
        matrix_row_t e;
        bit [31:0] got[4];
        if (aresetn && s_valid && s_ready) begin
            predict_matrices(s_ref_x, s_ref_y, s_ref_z, s_normal_x, s_normal_y, s_normal_z,
                             s_up_x, s_up_y, s_up_z);
        end
        if (aresetn && m_valid && m_ready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row word: which %0d row %0d", $time,
                         m_which_matrix, m_row_index);
                mismatches++;
            end else begin
                e = rows_due.pop_front();
                got[0] = m_col0; got[1] = m_col1; got[2] = m_col2; got[3] = m_col3;
                if (m_which_matrix !== e.which) begin
                    $display("%0t: which_matrix expected %0d got %0d", $time,
                             e.which, m_which_matrix);
                    mismatches++;
                end
                if (m_row_index !== e.row) begin
                    $display("%0t: row_index expected %0d got %0d", $time,
                             e.row, m_row_index);
                    mismatches++;
                end
                for (int j = 0; j < 4; j++) begin
                    if (got[j] !== e.cols[j]) begin
                        $display("%0t: col%0d expected %h got %h", $time, j,
                                 e.cols[j], got[j]);
                        mismatches++;
                    end
                end
                if (m_degenerate !== e.degen) begin
                    $display("%0t: degenerate expected %0d got %0d", $time,
                             e.degen, m_degenerate);
                    mismatches++;
                end
                if (m_last !== e.last) begin
                    $display("%0t: last expected %0d got %0d", $time, e.last, m_last);
                    mismatches++;
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, flow control and verdict for the look-at view matrix core.
`timescale 1ns / 100ps

module testbench;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    wire         s_ready;
    logic [31:0] s_ref_x, s_ref_y, s_ref_z;
    logic [31:0] s_normal_x, s_normal_y, s_normal_z;
    logic [31:0] s_up_x, s_up_y, s_up_z;
    wire         m_valid;
    logic        m_ready;
    wire         m_which_matrix;
    wire [1:0]   m_row_index;
    wire [31:0]  m_col0, m_col1, m_col2, m_col3;
    wire         m_degenerate;
    wire         m_last;

    int mismatches, rows_pending, rows_seen, degen_items;
    int items_sent;
    bit hold_output;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] ONE_Q   = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;

    look_at_view_matrix_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ref_x(s_ref_x), .s_ref_y(s_ref_y), .s_ref_z(s_ref_z),
        .s_normal_x(s_normal_x), .s_normal_y(s_normal_y), .s_normal_z(s_normal_z),
        .s_up_x(s_up_x), .s_up_y(s_up_y), .s_up_z(s_up_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_which_matrix(m_which_matrix), .m_row_index(m_row_index),
        .m_col0(m_col0), .m_col1(m_col1), .m_col2(m_col2), .m_col3(m_col3),
        .m_degenerate(m_degenerate), .m_last(m_last)
    );

    look_at_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ref_x(s_ref_x), .s_ref_y(s_ref_y), .s_ref_z(s_ref_z),
        .s_normal_x(s_normal_x), .s_normal_y(s_normal_y), .s_normal_z(s_normal_z),
        .s_up_x(s_up_x), .s_up_y(s_up_y), .s_up_z(s_up_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_which_matrix(m_which_matrix), .m_row_index(m_row_index),
        .m_col0(m_col0), .m_col1(m_col1), .m_col2(m_col2), .m_col3(m_col3),
        .m_degenerate(m_degenerate), .m_last(m_last),
        .mismatches(mismatches), .rows_pending(rows_pending),
        .rows_seen(rows_seen), .degen_items(degen_items)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
            2: return 32'($signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000);
            3: return 32'd0;
            4: return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
            default: return $urandom;
        endcase
    endfunction

    // Drive one word and hold it until taken; sampling at the falling edge keeps it race free.
    task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                             bit no_gap);
        int g;
        s_valid <= 1'b1;
        s_ref_x <= px; s_ref_y <= py; s_ref_z <= pz;
        s_normal_x <= nx; s_normal_y <= ny; s_normal_z <= nz;
        s_up_x <= ux; s_up_y <= uy; s_up_z <= uz;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_random(bit no_gap);
        logic [31:0] n[3], u[3];
        int k;
        for (int i = 0; i < 3; i++) n[i] = rand_field();
        k = $urandom_range(0, 9);
        if (k < 2) begin
            // up parallel to the normal, scaled by a small integer
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++) begin
                n[i] = 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
                u[i] = 32'($signed(n[i]) * k);
            end
        end else begin
            for (int i = 0; i < 3; i++) u[i] = rand_field();
        end
        send_word(rand_field(), rand_field(), rand_field(), n[0], n[1], n[2],
                  u[0], u[1], u[2], no_gap);
    endtask

    always begin
        @(posedge aclk);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_output) begin
            m_ready <= 1'b0;
            repeat (400) @(posedge aclk);
            hold_output = 0;
        end else if ($urandom_range(0, 99) < 25) begin
            m_ready <= 1'b0;
            repeat (gap_len() + 1) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        items_sent = 0;
        hold_output = 0;
        aresetn = 1'b0;
        m_ready = 1'b0;
        s_valid = 1'b0;
        {s_ref_x, s_ref_y, s_ref_z} = '0;
        {s_normal_x, s_normal_y, s_normal_z} = '0;
        {s_up_x, s_up_y, s_up_z} = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(0, 0, 0, 0, 0, ONE_Q, 0, ONE_Q, 0, 0);
        send_word(ONE_Q, NEG_ONE, ONE_Q, ONE_Q, 0, 0, 0, 0, ONE_Q, 0);
        send_word(0, 0, 0, 0, 0, 0, 0, ONE_Q, 0, 0);
        send_word(ONE_Q, ONE_Q, ONE_Q, 0, 0, ONE_Q, 0, 0, 0, 0);
        send_word(0, 0, 0, 0, ONE_Q, 0, 0, NEG_ONE, 0, 0);
        send_word(0, 0, 0, ONE_Q, ONE_Q, ONE_Q, 32'h0003_0000, 32'h0003_0000,
                  32'h0003_0000, 0);
        send_word(MAX_POS, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG, MAX_NEG,
                  MAX_NEG, MAX_POS, MAX_NEG, 0);
        send_word(MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS, MAX_POS, MAX_POS,
                  MAX_POS, MAX_NEG, 0, 0);
        send_word(MAX_NEG, MAX_POS, MAX_NEG, MAX_NEG, 0, 0, 0, MAX_NEG, 0, 0);
        send_word(MAX_POS, MAX_NEG, MAX_POS, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 0);
        send_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd2,
                  32'd3, 32'hFFFF_FFFF, 32'd1, 0);
        send_word(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, NEG_ONE, NEG_ONE, NEG_ONE,
                  ONE_Q, 0, 0, 0);
        send_word(0, 0, 0, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0);
        send_word(MAX_POS, 0, 0, 0, ONE_Q, 0, MAX_POS, 0, 0, 0);

        for (int i = 0; i < 80; i++) send_random(0);

        // stall the output long enough to back up the pipeline into the input
        hold_output = 1;
        for (int i = 0; i < 100; i++) send_random(1);
        s_valid <= 1'b0;
        wait (rows_pending == 0);
        @(posedge aclk);

        for (int i = 0; i < 60; i++) send_random($urandom_range(0, 3) == 0);
        s_valid <= 1'b0;
        wait (rows_pending == 0);
        @(posedge aclk);

        for (int i = 0; i < 80; i++) send_random(0);
        s_valid <= 1'b0;

        wait (rows_pending == 0);
        repeat (200) @(posedge aclk);
        $display("Sent %0d view setups (%0d degenerate), checked %0d matrix rows.",
                 items_sent, degen_items, rows_seen);
        if (mismatches == 0 && rows_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
